FILE: hdl/gca_pkg.sv
package gca_pkg;

  // Defaults for the top-level parameters
  localparam int CORDIC_STEPS_DEF = 32;
  localparam int DEG_FRAC_DEF     = 20;

  // Unit value of the Q60 angle and trigonometric formats
  localparam logic [63:0] ONE_Q60 = 64'd1 << 60;

  // Width of a coordinate difference and steps of the square root
  localparam int DIFF_W     = 30;
  localparam int ROOT_STEPS = 31;

  // Table of CORDIC arctangents, Q60, entry i is atan(2^-i)
  typedef logic [63:0][63:0] atan_tab_t;

  // Partial products of a 61 by 61 bit multiplication
  typedef struct packed {
    logic [59:0] hh;
    logic [60:0] hl;
    logic [60:0] lh;
    logic [61:0] ll;
  } pp_t;

  // Restoring division, used while building constants only
  function automatic logic [63:0] udiv(logic [63:0] n, logic [63:0] d);
    logic [63:0] q;
    logic [63:0] r;
    q = '0;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[62:0], n[i]};
      if (r >= d) begin
        r    = r - d;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // Low 64 bits of (a * b) >> sh over the full product
  function automatic logic [63:0] mul_shift(logic [63:0] a, logic [63:0] b, int sh);
    logic [127:0] p;
    p = 128'(a) * 128'(b);
    p = p >> sh;
    return p[63:0];
  endfunction

  // Alternating arctangent series
  function automatic logic [63:0] atan_series(logic [63:0] p, logic [63:0] dv, int sh);
    logic [63:0] sum;
    logic [63:0] t;
    logic [63:0] pw;
    sum = '0;
    pw  = p;
    for (int k = 0; k < 64; k++) begin
      if (pw != 64'd0) begin
        t = udiv(pw, 64'(2 * k + 1));
        if ((k & 1) == 1) sum = sum - t;
        else sum = sum + t;
        pw = udiv(pw, dv);
        pw = (sh < 64) ? (pw >> sh) : 64'd0;
      end
    end
    return sum;
  endfunction

  function automatic atan_tab_t atan_table();
    atan_tab_t t;
    for (int i = 0; i < 64; i++) begin
      if (i == 0) begin
        t[i] = atan_series(ONE_Q60 >> 1, 64'd4, 0)
             + atan_series(udiv(ONE_Q60, 64'd3), 64'd9, 0);
      end else if (i < 61) begin
        t[i] = atan_series(ONE_Q60 >> i, 64'd1, 2 * i);
      end else begin
        t[i] = '0;
      end
    end
    return t;
  endfunction

  function automatic logic [63:0] pi_q60();
    atan_tab_t t;
    t = atan_table();
    return t[0] << 2;
  endfunction

  // pi / 180 in Q62
  function automatic logic [63:0] deg_to_rad_q62();
    return udiv(pi_q60(), 64'd45);
  endfunction

  // Reciprocal of the CORDIC gain, Newton iteration on the gain product
  function automatic logic [63:0] inv_gain_q60(int steps);
    logic [63:0] prod;
    logic [63:0] y;
    logic [63:0] t;
    prod = ONE_Q60;
    for (int i = 0; i < steps; i++) begin
      if (2 * i < 64) prod = prod + (prod >> (2 * i));
    end
    y = udiv(64'd6 << 60, 64'd10);
    for (int i = 0; i < 8; i++) begin
      t = mul_shift(prod, mul_shift(y, y, 60), 60);
      y = mul_shift(y, (64'd3 << 60) - t, 61);
    end
    return y;
  endfunction

  // Number of subtract steps that bring a difference below 360 degrees
  function automatic int red_steps(int frac);
    int          n;
    logic [63:0] m;
    n = 0;
    m = 64'd360 << frac;
    for (int k = 0; k < 40; k++) begin
      if ((m << k) <= (64'd1 << (DIFF_W - 1))) n++;
    end
    return n;
  endfunction

  function automatic logic [60:0] clamp_unit(logic signed [63:0] v);
    logic [60:0] r;
    if (v < 0) r = '0;
    else if (v > $signed(ONE_Q60)) r = ONE_Q60[60:0];
    else r = v[60:0];
    return r;
  endfunction

  function automatic pp_t pp_make(logic [60:0] a, logic [60:0] b);
    pp_t p;
    p.hh = 60'(a[60:31]) * 60'(b[60:31]);
    p.hl = 61'(a[60:31]) * 61'(b[30:0]);
    p.lh = 61'(a[30:0]) * 61'(b[60:31]);
    p.ll = 62'(a[30:0]) * 62'(b[30:0]);
    return p;
  endfunction

  // Sum partial products and scale back to Q60
  function automatic logic [60:0] pp_sum(pp_t p);
    logic [121:0] s;
    s = (122'(p.hh) << 62) + (122'(p.hl) << 31) + (122'(p.lh) << 31) + 122'(p.ll);
    return s[120:60];
  endfunction

endpackage

FILE: hdl/great_circle_angle_unit.sv
// Great circle angle between two positions, haversine rule.
// Input: pulse start with lat_first, lat_second (28 bit) and lon_first,
// lon_second (29 bit), signed degrees with DEGREE_FRAC_BITS fraction bits.
// busy is held low: a new pair is taken on every cycle that start is high.
// Output: done is high for one cycle with central_angle (radians, unsigned,
// 30 fraction bits) and clamped (haversine term rounded above one).
// The receiver cannot hold results off; every result is shown once.
// The modulo-360 reduction has R subtract steps (R = 1 at 20 fraction bits).
// Throughput is one pair per cycle: four rotation CORDICs, the square
// roots and the vectoring CORDIC are fully unrolled, one step per stage.
// Reset clears the valid chain only; items in flight are dropped.
module great_circle_angle_unit #(
  parameter int CORDIC_STEPS     = gca_pkg::CORDIC_STEPS_DEF,
  parameter int DEGREE_FRAC_BITS = gca_pkg::DEG_FRAC_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [27:0] lat_first,
  input  logic signed [27:0] lat_second,
  input  logic signed [28:0] lon_first,
  input  logic signed [28:0] lon_second,
  output logic               done,
  output logic [31:0]        central_angle,
  output logic               clamped
);

  localparam int CS   = CORDIC_STEPS;
  localparam int F    = DEGREE_FRAC_BITS;
  localparam int NRED = gca_pkg::red_steps(F);
  localparam int RS   = gca_pkg::ROOT_STEPS;
  localparam int LAT  = 44 + NRED + 2 * CS;
  localparam int SQ_DONE = 42 + NRED + CS;

  localparam logic [63:0] ONE      = gca_pkg::ONE_Q60;
  localparam logic [63:0] MOD360   = 64'd360 << F;
  localparam logic [63:0] HALF360  = 64'd180 << F;
  localparam logic [63:0] PI_Q     = gca_pkg::pi_q60();
  localparam logic [63:0] HALF_PI  = PI_Q >> 1;
  localparam logic [63:0] D2R      = gca_pkg::deg_to_rad_q62();
  localparam logic [63:0] INV_GAIN = gca_pkg::inv_gain_q60(CS);
  localparam gca_pkg::atan_tab_t ATAN = gca_pkg::atan_table();
  localparam logic [63:0] RND_MAX  = HALF_PI + (64'd1 << 28);
  localparam logic [31:0] ANGLE_MAX = RND_MAX[60:29];

  logic [LAT-1:0]     vld;
  logic signed [29:0] v [0:3];
  logic [29:0]        rd [0:NRED][0:3];
  logic [31:0]        red [0:3];
  logic [63:0]        prl [0:3];
  logic [63:0]        prh [0:3];
  logic [63:0]        ang [0:3];
  logic [63:0]        z0 [0:3];
  logic signed [63:0] rx [0:CS][0:3];
  logic signed [63:0] ry [0:CS][0:3];
  logic signed [63:0] rz [0:CS][0:3];
  logic [CS:0]        rsub;
  logic [60:0]        trig [0:3];
  logic [4:0]         sub_d;
  gca_pkg::pp_t       p1 [0:2];
  gca_pkg::pp_t       p2;
  logic [60:0]        cc_ab;
  logic [60:0]        slat2;
  logic [60:0]        slon2;
  logic [60:0]        slat2_d;
  logic [60:0]        slat2_e;
  logic [60:0]        cross_term;
  logic signed [62:0] h_sum;
  logic [61:0]        sv [0:RS][0:1];
  logic [61:0]        sr [0:RS][0:1];
  logic [RS:0]        scl;
  logic signed [63:0] vx0;
  logic signed [63:0] vy0;
  logic signed [63:0] vx [0:CS-1];
  logic signed [63:0] vy [0:CS-1];
  logic signed [63:0] vz [0:CS-1];
  logic [CS-1:0]      vcl;
  logic [63:0]        z_cl;
  logic [63:0]        z_rnd;

  assign busy = 1'b0;
  assign done = vld[LAT-1];

  // Advance the valid chain, one bit per register stage
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[LAT-2:0], start};
    end
  end

  // Capture the beat: two differences and the two latitudes
  always_ff @(posedge clk) begin
    v[0] <= {{2{lat_second[27]}}, lat_second} - {{2{lat_first[27]}}, lat_first};
    v[1] <= {lon_second[28], lon_second} - {lon_first[28], lon_first};
    v[2] <= {{2{lat_first[27]}}, lat_first};
    v[3] <= {{2{lat_second[27]}}, lat_second};
  end

  // Reduce magnitudes modulo 360 degrees, one binary subtract per stage
  always_ff @(posedge clk) begin
    for (int l = 0; l < 4; l++) begin
      rd[0][l] <= v[l][29] ? $unsigned(-v[l]) : $unsigned(v[l]);
      for (int j = 0; j < NRED; j++) begin
        if (64'(rd[j][l]) >= (MOD360 << (NRED - 1 - j))) begin
          rd[j+1][l] <= rd[j][l] - 30'(MOD360 << (NRED - 1 - j));
        end else begin
          rd[j+1][l] <= rd[j][l];
        end
      end
      // fold into 0 .. 180 degrees
      if (64'(rd[NRED][l]) > HALF360) red[l] <= 32'(MOD360 - 64'(rd[NRED][l]));
      else red[l] <= 32'(rd[NRED][l]);
    end
  end

  // Degrees to radians: split multiply, then sum and scale
  always_ff @(posedge clk) begin
    for (int l = 0; l < 4; l++) begin
      prl[l] <= 64'(red[l]) * 64'(D2R[31:0]);
      prh[l] <= 64'(red[l]) * 64'(D2R[63:32]);
      if (l < 2) ang[l] <= 64'(((96'(prh[l]) << 32) + 96'(prl[l])) >> (F + 3));
      else ang[l] <= 64'(((96'(prh[l]) << 32) + 96'(prl[l])) >> (F + 2));
    end
  end

  // Bring every angle into 0 .. pi/2; latitudes past 90 degrees flip cosine
  always_comb begin
    for (int l = 0; l < 4; l++) begin
      if (ang[l] <= HALF_PI) z0[l] = ang[l];
      else if (l < 2) z0[l] = HALF_PI;
      else if (ang[l] > PI_Q) z0[l] = '0;
      else z0[l] = PI_Q - ang[l];
    end
  end

  // Rotation CORDIC on four lanes, one iteration per stage
  always_ff @(posedge clk) begin
    rsub[0] <= (ang[2] > HALF_PI) ^ (ang[3] > HALF_PI);
    for (int l = 0; l < 4; l++) begin
      rx[0][l] <= $signed(INV_GAIN);
      ry[0][l] <= '0;
      rz[0][l] <= $signed(z0[l]);
    end
    for (int i = 0; i < CS; i++) begin
      rsub[i+1] <= rsub[i];
      for (int l = 0; l < 4; l++) begin
        if (rz[i][l] >= 0) begin
          rx[i+1][l] <= rx[i][l] - (ry[i][l] >>> i);
          ry[i+1][l] <= ry[i][l] + (rx[i][l] >>> i);
          rz[i+1][l] <= rz[i][l] - $signed(ATAN[i]);
        end else begin
          rx[i+1][l] <= rx[i][l] + (ry[i][l] >>> i);
          ry[i+1][l] <= ry[i][l] - (rx[i][l] >>> i);
          rz[i+1][l] <= rz[i][l] + $signed(ATAN[i]);
        end
      end
    end
  end

  // Clamp trig results, then form the haversine products
  always_ff @(posedge clk) begin
    trig[0]    <= gca_pkg::clamp_unit(ry[CS][0]);
    trig[1]    <= gca_pkg::clamp_unit(ry[CS][1]);
    trig[2]    <= gca_pkg::clamp_unit(rx[CS][2]);
    trig[3]    <= gca_pkg::clamp_unit(rx[CS][3]);
    sub_d      <= {sub_d[3:0], rsub[CS]};
    p1[0]      <= gca_pkg::pp_make(trig[2], trig[3]);
    p1[1]      <= gca_pkg::pp_make(trig[0], trig[0]);
    p1[2]      <= gca_pkg::pp_make(trig[1], trig[1]);
    cc_ab      <= gca_pkg::pp_sum(p1[0]);
    slat2      <= gca_pkg::pp_sum(p1[1]);
    slon2      <= gca_pkg::pp_sum(p1[2]);
    p2         <= gca_pkg::pp_make(cc_ab, slon2);
    slat2_d    <= slat2;
    cross_term <= gca_pkg::pp_sum(p2);
    slat2_e    <= slat2_d;
  end

  // Combine the two haversine terms
  always_comb begin
    if (sub_d[4]) h_sum = $signed({2'b00, slat2_e}) - $signed({2'b00, cross_term});
    else h_sum = $signed({2'b00, slat2_e}) + $signed({2'b00, cross_term});
  end

  // Clamp h, then integer square roots of h and 1 - h, one bit per stage
  always_ff @(posedge clk) begin
    sr[0][0] <= '0;
    sr[0][1] <= '0;
    if (h_sum < 0) begin
      sv[0][0] <= '0;
      sv[0][1] <= ONE[61:0];
      scl[0]   <= 1'b0;
    end else if (h_sum > $signed(63'(ONE))) begin
      sv[0][0] <= ONE[61:0];
      sv[0][1] <= '0;
      scl[0]   <= 1'b1;
    end else begin
      sv[0][0] <= h_sum[61:0];
      sv[0][1] <= ONE[61:0] - h_sum[61:0];
      scl[0]   <= 1'b0;
    end
    for (int j = 0; j < RS; j++) begin
      scl[j+1] <= scl[j];
      for (int l = 0; l < 2; l++) begin
        if (sv[j][l] >= sr[j][l] + (62'd1 << (2 * (RS - 1 - j)))) begin
          sv[j+1][l] <= sv[j][l] - (sr[j][l] + (62'd1 << (2 * (RS - 1 - j))));
          sr[j+1][l] <= (sr[j][l] >> 1) + (62'd1 << (2 * (RS - 1 - j)));
        end else begin
          sv[j+1][l] <= sv[j][l];
          sr[j+1][l] <= sr[j][l] >> 1;
        end
      end
    end
  end

  // Start vector for the arctangent: sqrt(1 - h), sqrt(h) in Q60
  assign vx0 = {3'b000, sr[RS][1][30:0], 30'd0};
  assign vy0 = {3'b000, sr[RS][0][30:0], 30'd0};

  // Vectoring CORDIC, one iteration per stage
  always_ff @(posedge clk) begin
    vcl[0] <= scl[RS];
    if (vy0 > 0) begin
      vx[0] <= vx0 + vy0;
      vy[0] <= vy0 - vx0;
      vz[0] <= $signed(ATAN[0]);
    end else begin
      vx[0] <= vx0 - vy0;
      vy[0] <= vy0 + vx0;
      vz[0] <= -$signed(ATAN[0]);
    end
    for (int i = 1; i < CS; i++) begin
      vcl[i] <= vcl[i-1];
      if (vy[i-1] > 0) begin
        vx[i] <= vx[i-1] + (vy[i-1] >>> i);
        vy[i] <= vy[i-1] - (vx[i-1] >>> i);
        vz[i] <= vz[i-1] + $signed(ATAN[i]);
      end else begin
        vx[i] <= vx[i-1] - (vy[i-1] >>> i);
        vy[i] <= vy[i-1] + (vx[i-1] >>> i);
        vz[i] <= vz[i-1] - $signed(ATAN[i]);
      end
    end
  end

  // Clamp the half angle to 0 .. pi/2 and round the full angle to 30 fraction bits
  always_comb begin
    if (vz[CS-1] < 0) z_cl = '0;
    else if ($unsigned(vz[CS-1]) > HALF_PI) z_cl = HALF_PI;
    else z_cl = $unsigned(vz[CS-1]);
    z_rnd = z_cl + (64'd1 << 28);
  end

  always_ff @(posedge clk) begin
    central_angle <= z_rnd[60:29];
    clamped       <= vcl[CS-1];
  end

  // Each result beat comes from exactly one accepted pair
  a_done_from_start: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, LAT))
    else $error("result beat without a matching start");

  // The angle never exceeds pi
  a_angle_range: assert property (@(posedge clk) disable iff (rst)
    done |-> central_angle <= ANGLE_MAX)
    else $error("central angle above pi");

  // The two roots square back to one within rounding
  a_root_pair: assert property (@(posedge clk) disable iff (rst)
    vld[SQ_DONE] |->
      ((64'(sr[RS][0][30:0]) * 64'(sr[RS][0][30:0])
        + 64'(sr[RS][1][30:0]) * 64'(sr[RS][1][30:0])) <= ONE) &&
      ((64'(sr[RS][0][30:0]) * 64'(sr[RS][0][30:0])
        + 64'(sr[RS][1][30:0]) * 64'(sr[RS][1][30:0])) > ONE - (64'd1 << 32)))
    else $error("square root pair out of bounds");

endmodule

FILE: dv/gca_checker.sv
`timescale 1ns / 1ps

module gca_checker #(
  parameter int CORDIC_STEPS     = 32,
  parameter int DEGREE_FRAC_BITS = 20
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               busy,
  input  logic signed [27:0] lat_first,
  input  logic signed [27:0] lat_second,
  input  logic signed [28:0] lon_first,
  input  logic signed [28:0] lon_second,
  input  logic               done,
  input  logic [31:0]        central_angle,
  input  logic               clamped,
  output int                 errors,
  output int                 pending
);

  typedef struct packed {
    logic [31:0] angle;
    logic        clamp;
  } angle_beat_t;

  localparam logic [63:0] UNIT = 64'd1 << 60;

  logic [63:0] arc_tab [CORDIC_STEPS];
  logic [63:0] pi_val;
  logic [63:0] deg_rad;
  logic [63:0] gain_inv;
  angle_beat_t angle_q[$];

  function automatic logic [63:0] mshift(logic [63:0] a, logic [63:0] b, int sh);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    p = p >> sh;
    return p[63:0];
  endfunction

  function automatic logic [63:0] arc_series(logic [63:0] p, logic [63:0] dv, int sh);
    logic [63:0] acc;
    logic [63:0] k;
    acc = 0;
    k = 0;
    while (p != 0) begin
      if (k[0]) acc = acc - p / (2 * k + 1);
      else acc = acc + p / (2 * k + 1);
      p = p / dv;
      p = (sh < 64) ? (p >> sh) : 64'd0;
      k++;
    end
    return acc;
  endfunction

  function automatic logic [63:0] root_floor(logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // magnitude of an angle folded into 0 .. 180 degrees
  function automatic logic [63:0] fold_deg(longint v);
    longint m;
    longint r;
    m = longint'(360) << DEGREE_FRAC_BITS;
    r = v % m;
    if (r > m / 2) r -= m;
    if (r < -(m / 2)) r += m;
    return (r < 0) ? -r : r;
  endfunction

  function automatic logic [63:0] unit_clip(longint v);
    if (v < 0) return 0;
    if (v > longint'(UNIT)) return UNIT;
    return v;
  endfunction

  function automatic void rotate(logic [63:0] ang, output logic [63:0] c, output logic [63:0] s);
    longint x;
    longint y;
    longint z;
    longint dx;
    longint dy;
    x = gain_inv;
    y = 0;
    z = ang;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(arc_tab[i]);
      end else begin
        x += dx; y -= dy; z += longint'(arc_tab[i]);
      end
    end
    c = unit_clip(x);
    s = unit_clip(y);
  endfunction

  function automatic logic [63:0] lat_cosine(longint lat, output bit neg);
    logic [63:0] a;
    logic [63:0] c;
    logic [63:0] s;
    a = mshift(fold_deg(lat), deg_rad, DEGREE_FRAC_BITS + 2);
    neg = 0;
    if (a > (pi_val >> 1)) begin
      a = (a > pi_val) ? 64'd0 : pi_val - a;
      neg = 1;
    end
    rotate(a, c, s);
    return c;
  endfunction

  function automatic logic [63:0] half_sin_sq(longint d);
    logic [63:0] a;
    logic [63:0] c;
    logic [63:0] s;
    a = mshift(fold_deg(d), deg_rad, DEGREE_FRAC_BITS + 3);
    if (a > (pi_val >> 1)) a = pi_val >> 1;
    rotate(a, c, s);
    return mshift(s, s, 60);
  endfunction

  function automatic angle_beat_t haversine(longint la, longint lb, longint oa, longint ob);
    angle_beat_t res;
    bit na;
    bit nb;
    logic [63:0] ca;
    logic [63:0] cb;
    logic [63:0] cross_term;
    logic [63:0] s_lat;
    logic [63:0] zo;
    longint h;
    longint x;
    longint y;
    longint z;
    longint dx;
    longint dy;
    res.clamp = 0;
    s_lat = half_sin_sq(lb - la);
    cross_term = half_sin_sq(ob - oa);
    ca = lat_cosine(la, na);
    cb = lat_cosine(lb, nb);
    cross_term = mshift(mshift(ca, cb, 60), cross_term, 60);
    h = (na != nb) ? longint'(s_lat) - longint'(cross_term)
                   : longint'(s_lat) + longint'(cross_term);
    if (h < 0) begin
      h = 0;
    end else if (h > longint'(UNIT)) begin
      h = UNIT;
      res.clamp = 1;
    end
    // vector (sqrt(1-h), sqrt(h)) onto the x axis
    y = root_floor(h) << 30;
    x = root_floor(UNIT - h) << 30;
    z = 0;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y > 0) begin
        x += dx; y -= dy; z += longint'(arc_tab[i]);
      end else begin
        x -= dx; y += dy; z -= longint'(arc_tab[i]);
      end
    end
    if (z < 0) z = 0;
    zo = (z > longint'(pi_val >> 1)) ? (pi_val >> 1) : z;
    zo = (zo + (64'd1 << 28)) >> 29;
    res.angle = zo[31:0];
    return res;
  endfunction

  // build arctangents, pi/180 and the gain correction
  initial begin
    logic [63:0] prod;
    logic [63:0] y;
    logic [63:0] t;
    prod = UNIT;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      if (i == 0) arc_tab[i] = arc_series(UNIT / 2, 4, 0) + arc_series(UNIT / 3, 9, 0);
      else arc_tab[i] = (i < 61) ? arc_series(UNIT >> i, 1, 2 * i) : 64'd0;
      if (2 * i < 64) prod = prod + (prod >> (2 * i));
    end
    pi_val = 4 * arc_tab[0];
    deg_rad = pi_val / 45;
    y = (64'd6 << 60) / 10;
    for (int i = 0; i < 8; i++) begin
      t = mshift(prod, mshift(y, y, 60), 60);
      y = mshift(y, (64'd3 << 60) - t, 61);
    end
    gain_inv = y;
  end

  // queue a prediction per accepted beat, compare each result beat
  always @(posedge clk) begin
    angle_beat_t want;
    if (rst) begin
      errors <= 0;
    end else begin
      if (start && !busy)
        angle_q.push_back(haversine(lat_first, lat_second, lon_first, lon_second));
      if (done) begin
        if (angle_q.size() == 0) begin
          if (errors < 10) $display("unexpected result beat: angle %0d clamped %0b",
                                    central_angle, clamped);
          errors <= errors + 1;
        end else begin
          want = angle_q.pop_front();
          if (want.angle !== central_angle || want.clamp !== clamped) begin
            if (errors < 10)
              $display("mismatch: angle exp %0d got %0d, clamped exp %0b got %0b",
                       want.angle, central_angle, want.clamp, clamped);
            errors <= errors + 1;
          end
        end
      end
    end
    pending <= angle_q.size();
  end

endmodule

FILE: dv/tb_great_circle_angle_unit.sv
`timescale 1ns / 1ps

module tb_great_circle_angle_unit;

  localparam int LAT_MAX   = 94371840;
  localparam int LON_MAX   = 188743680;
  localparam int ONE_DEG   = 1 << 20;
  localparam int N_RANDOM  = 1800;
  localparam int CYC_LIMIT = 200000;

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  logic signed [27:0] lat_first;
  logic signed [27:0] lat_second;
  logic signed [28:0] lon_first;
  logic signed [28:0] lon_second;
  logic               done;
  logic [31:0]        central_angle;
  logic               clamped;
  int                 errors;
  int                 pending;
  int                 cycles;
  bit                 calm;

  great_circle_angle_unit uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .lat_first(lat_first), .lat_second(lat_second),
    .lon_first(lon_first), .lon_second(lon_second),
    .done(done), .central_angle(central_angle), .clamped(clamped)
  );

  gca_checker chk (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .lat_first(lat_first), .lat_second(lat_second),
    .lon_first(lon_first), .lon_second(lon_second),
    .done(done), .central_angle(central_angle), .clamped(clamped),
    .errors(errors), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // bound the run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYC_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic int clip(int v, int lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  // hold a pair on the ports until taken, then maybe idle a burst
  task automatic send_pair(int la, int lb, int oa, int ob);
    start      <= 1'b1;
    lat_first  <= 28'(la);
    lat_second <= 28'(lb);
    lon_first  <= 29'(oa);
    lon_second <= 29'(ob);
    @(posedge clk);
    while (busy) @(posedge clk);
    if (!calm && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  initial begin
    int la;
    int lb;
    int oa;
    cycles     = 0;
    calm       = 0;
    rst        = 1'b1;
    start      = 1'b0;
    lat_first  = '0;
    lat_second = '0;
    lon_first  = '0;
    lon_second = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // extremes, identical points, poles, antipodes, dateline
    send_pair(0, 0, 0, 0);
    send_pair(LAT_MAX, LAT_MAX, LON_MAX, LON_MAX);
    send_pair(-LAT_MAX, -LAT_MAX, -LON_MAX, -LON_MAX);
    send_pair(LAT_MAX, -LAT_MAX, 0, 0);
    send_pair(-LAT_MAX, LAT_MAX, LON_MAX, -LON_MAX);
    send_pair(0, 0, -LON_MAX, LON_MAX);
    send_pair(0, 0, 0, LON_MAX);
    send_pair(0, 0, -LON_MAX, 0);
    send_pair(45 * ONE_DEG, -45 * ONE_DEG, 10 * ONE_DEG, -170 * ONE_DEG);
    send_pair(30 * ONE_DEG, -30 * ONE_DEG, -90 * ONE_DEG, 90 * ONE_DEG);
    send_pair(LAT_MAX, 0, 0, LON_MAX);
    send_pair(1, 0, 0, 1);
    send_pair(-1, -1, -1, 1);
    send_pair(LAT_MAX - 1, -LAT_MAX + 1, LON_MAX - 1, -LON_MAX + 1);
    send_pair(0, LAT_MAX, -LON_MAX, -LON_MAX);
    send_pair(-LAT_MAX, 12345678, 98765432, -LON_MAX);
    send_pair(179 * ONE_DEG / 2, -179 * ONE_DEG / 2, 0, 180 * ONE_DEG - 7);

    // random pairs, a share near the antipode to push h towards one
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n > N_RANDOM - 200) calm = 1;
      la = $urandom_range(0, 2 * LAT_MAX) - LAT_MAX;
      oa = $urandom_range(0, 2 * LON_MAX) - LON_MAX;
      case ($urandom_range(0, 4))
        0: begin
          lb = clip(-la + $urandom_range(0, 64) - 32, LAT_MAX);
          send_pair(la, lb, oa,
                    clip(oa + ((oa < 0) ? 1 : -1) * 180 * ONE_DEG
                         + $urandom_range(0, 64) - 32, LON_MAX));
        end
        1: begin
          lb = clip(la + $urandom_range(0, 2048) - 1024, LAT_MAX);
          send_pair(la, lb, oa, clip(oa + $urandom_range(0, 2048) - 1024, LON_MAX));
        end
        default: begin
          lb = $urandom_range(0, 2 * LAT_MAX) - LAT_MAX;
          send_pair(la, lb, oa, $urandom_range(0, 2 * LON_MAX) - LON_MAX);
        end
      endcase
    end
    start <= 1'b0;

    // drain the pipeline, then allow for any stray beat
    while (pending != 0) @(posedge clk);
    repeat (150) @(posedge clk);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

FILE: great_circle_angle_unit.f
hdl/gca_pkg.sv
hdl/great_circle_angle_unit.sv
dv/gca_checker.sv
dv/tb_great_circle_angle_unit.sv
